@@ design/double_ended_queue_unit_macros.svh @@
// ----------------------------------------------------------------------------
// double_ended_queue_unit_macros : assertion helpers for the deque checker
// wraps the clocking, reset disable and error report of each property
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and constants of the double-ended queue unit
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;
    localparam int REQ_W   = 2;

    typedef logic signed [WORD_W-1:0] t_word;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } t_req;

    // per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic shift_right;  // push front: every element moves one cell back
        logic shift_left;   // pop front: every element moves one cell forward
        logic push_back;    // the first free cell takes the pushed word
        logic pop_back;     // the last held cell drops its element
    } t_cell_ctrl;

endpackage

@@ design/deq_cell.sv @@
// ----------------------------------------------------------------------------
// deq_cell
// one slot of the deque row: holds a word and a valid bit, trades with its
// neighbors on front transfers and decides locally on back transfers
// ----------------------------------------------------------------------------
module deq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  deq_pkg::t_cell_ctrl i_ctrl,
    input  deq_pkg::t_word      i_push_value,
    input  logic                i_left_valid,
    input  deq_pkg::t_word      i_left_data,
    input  logic                i_right_valid,
    input  deq_pkg::t_word      i_right_data,
    output logic                o_valid,
    output deq_pkg::t_word      o_data,
    output deq_pkg::t_word      o_last_data
);

    logic           r_valid;
    logic           n_valid;
    deq_pkg::t_word r_data;
    deq_pkg::t_word n_data;
    logic           w_is_last;
    logic           w_is_free_edge;

    // this cell holds the back element, or is the first free one
    assign w_is_last      = r_valid && !i_right_valid;
    assign w_is_free_edge = i_left_valid && !r_valid;

    // next slot contents
    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctrl.shift_right) begin
            n_valid = i_left_valid;
            n_data  = i_left_data;
        end else if (i_ctrl.shift_left) begin
            n_valid = i_right_valid;
            n_data  = i_right_data;
        end else if (i_ctrl.push_back && w_is_free_edge) begin
            n_valid = 1'b1;
            n_data  = i_push_value;
        end else if (i_ctrl.pop_back && w_is_last) begin
            n_valid = 1'b0;
        end
    end

    // valid bit is control, word is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid     = r_valid;
    assign o_data      = r_data;
    assign o_last_data = w_is_last ? r_data : '0;

endmodule

@@ design/double_ended_queue_unit.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// bounded deque of signed words held in a row of shifting cells
// ----------------------------------------------------------------------------
// Usage:
//   A request (i_req_type, i_push_value) transfers at a clock edge where
//   start is high and busy is low. Pushes go to the front or back, pops
//   take from the front or back; a push on a full queue or a pop on an
//   empty one is flagged and changes nothing.
//   Each request gives one result, held on the o_ ports for exactly one
//   cycle while o_done is high: the popped word, the front and back words,
//   the element count and the empty, underflow and overflow flags.
//   The result passes from busy to the result registers, which load while
//   busy is high, and o_done follows busy. A new request cannot transfer
//   while busy is high. busy is high for the cycle after each transfer,
//   while the back word is gathered from the cell row through a
//   registered one-hot select. The element at the front always sits in
//   cell 0, so front transfers shift the whole row by one cell together.
//   Reset (synchronous, active low) empties the queue and drops any
//   result in flight. The receiver cannot stall: results are not held.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [deq_pkg::REQ_W-1:0]           i_req_type,
    input  logic signed [deq_pkg::WORD_W-1:0]   i_push_value,
    output logic                                o_done,
    output logic signed [deq_pkg::WORD_W-1:0]   o_popped_value,
    output logic signed [deq_pkg::WORD_W-1:0]   o_front_value,
    output logic signed [deq_pkg::WORD_W-1:0]   o_back_value,
    output logic [deq_pkg::COUNT_W-1:0]         o_element_count,
    output logic                                o_is_empty,
    output logic                                o_underflow,
    output logic                                o_overflow
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                 w_accept;
    deq_pkg::t_req        w_req;
    logic                 w_empty;
    logic                 w_full;
    deq_pkg::t_cell_ctrl  w_ctrl;
    logic                 w_valid     [DEPTH];
    deq_pkg::t_word       w_data      [DEPTH];
    deq_pkg::t_word       w_last_data [DEPTH];
    deq_pkg::t_word       w_back_sel;

    logic                 r_busy;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    deq_pkg::t_word       r_back;
    deq_pkg::t_word       r_popped;
    deq_pkg::t_word       n_popped;
    logic                 r_under;
    logic                 n_under;
    logic                 r_over;
    logic                 n_over;

    logic                 r_done;
    deq_pkg::t_word       r_out_popped;
    deq_pkg::t_word       r_out_front;
    deq_pkg::t_word       r_out_back;
    logic [deq_pkg::COUNT_W-1:0] r_out_count;
    logic                 r_out_empty;
    logic                 r_out_under;
    logic                 r_out_over;

    // request transfer and occupancy seen from the ends of the row
    assign w_accept = start && !r_busy;
    assign w_req    = deq_pkg::t_req'(i_req_type);
    assign w_empty  = !w_valid[0];
    assign w_full   = w_valid[DEPTH-1];

    // command to the cells, popped word, flags and next count
    always_comb begin
        w_ctrl   = '0;
        n_popped = '0;
        n_under  = 1'b0;
        n_over   = 1'b0;
        n_count  = r_count;
        case (w_req)
            deq_pkg::REQ_PUSH_FRONT: begin
                n_over             = w_full;
                w_ctrl.shift_right = w_accept && !w_full;
                if (!w_full) n_count = r_count + CNT_W'(1);
            end
            deq_pkg::REQ_PUSH_BACK: begin
                n_over           = w_full;
                w_ctrl.push_back = w_accept && !w_full;
                if (!w_full) n_count = r_count + CNT_W'(1);
            end
            deq_pkg::REQ_POP_FRONT: begin
                n_under           = w_empty;
                w_ctrl.shift_left = w_accept && !w_empty;
                if (!w_empty) begin
                    n_popped = w_data[0];
                    n_count  = r_count - CNT_W'(1);
                end
            end
            deq_pkg::REQ_POP_BACK: begin
                n_under         = w_empty;
                w_ctrl.pop_back = w_accept && !w_empty;
                if (!w_empty) begin
                    n_popped = r_back;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            default: begin
                w_ctrl = '0;
            end
        endcase
    end

    // row of cells, front element in cell 0
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic           w_lv;
        deq_pkg::t_word w_ld;
        logic           w_rv;
        deq_pkg::t_word w_rd;

        if (gi == 0) begin : g_head
            assign w_lv = 1'b1;
            assign w_ld = i_push_value;
        end else begin : g_mid_l
            assign w_lv = w_valid[gi-1];
            assign w_ld = w_data[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_rv = 1'b0;
            assign w_rd = '0;
        end else begin : g_mid_r
            assign w_rv = w_valid[gi+1];
            assign w_rd = w_data[gi+1];
        end

        deq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_push_value  (i_push_value),
            .i_left_valid  (w_lv),
            .i_left_data   (w_ld),
            .i_right_valid (w_rv),
            .i_right_data  (w_rd),
            .o_valid       (w_valid[gi]),
            .o_data        (w_data[gi]),
            .o_last_data   (w_last_data[gi])
        );
    end

    // one-hot gather of the back word: every cell but the last held one gives zero
    always_comb begin
        w_back_sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_back_sel = w_back_sel | w_last_data[i];
        end
    end

    // control: busy for one cycle after each transfer, element count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_busy <= w_accept;
            r_done <= r_busy;
            if (w_accept) r_count <= n_count;
        end
    end

    // request-side payload captured at the transfer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped <= n_popped;
            r_under  <= n_under;
            r_over   <= n_over;
        end
    end

    // result registers, loaded in the busy cycle once the row has settled
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_back       <= w_back_sel;
            r_out_popped <= r_popped;
            r_out_front  <= w_valid[0] ? w_data[0] : '0;
            r_out_back   <= w_back_sel;
            r_out_count  <= deq_pkg::COUNT_W'(r_count);
            r_out_empty  <= !w_valid[0];
            r_out_under  <= r_under;
            r_out_over   <= r_over;
        end
    end

    assign busy            = r_busy;
    assign o_done          = r_done;
    assign o_popped_value  = r_out_popped;
    assign o_front_value   = r_out_front;
    assign o_back_value    = r_out_back;
    assign o_element_count = r_out_count;
    assign o_is_empty      = r_out_empty;
    assign o_underflow     = r_out_under;
    assign o_overflow      = r_out_over;

endmodule

@@ design/deq_checker.sv @@
// ----------------------------------------------------------------------------
// deq_checker
// port-level properties of the double-ended queue unit, bound to the top
// ----------------------------------------------------------------------------
`include "double_ended_queue_unit_macros.svh"

module deq_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                o_done,
    input  logic signed [deq_pkg::WORD_W-1:0]   o_popped_value,
    input  logic signed [deq_pkg::WORD_W-1:0]   o_front_value,
    input  logic signed [deq_pkg::WORD_W-1:0]   o_back_value,
    input  logic [deq_pkg::COUNT_W-1:0]         o_element_count,
    input  logic                                o_is_empty,
    input  logic                                o_underflow,
    input  logic                                o_overflow
);

    // a transfer makes the unit busy in the next cycle
    `DEQ_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, start && !busy, busy, "busy missing after transfer")

    // every result comes from an earlier transfer
    `DEQ_ASSERT_NOW(a_done_has_source, i_clk, i_rst_n, o_done, $past(start && !busy && i_rst_n, 2), "result without transfer")

    // every transfer gives its result unless reset comes between
    `DEQ_ASSERT_NOW(a_transfer_gives_done, i_clk, i_rst_n, $past(start && !busy && i_rst_n, 2) && $past(i_rst_n), o_done, "transfer without result")

    // an empty queue shows zero count and zero end words
    `DEQ_ASSERT_NOW(a_empty_is_clean, i_clk, i_rst_n, o_done && o_is_empty, o_element_count == '0 && o_front_value == '0 && o_back_value == '0, "empty result not clean")

    // a refused request removes nothing
    `DEQ_ASSERT_NOW(a_refused_no_pop, i_clk, i_rst_n, o_done && (o_underflow || o_overflow), o_popped_value == '0 && !(o_underflow && o_overflow), "refused request popped a word")

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_popped_value  (o_popped_value),
    .o_front_value   (o_front_value),
    .o_back_value    (o_back_value),
    .o_element_count (o_element_count),
    .o_is_empty      (o_is_empty),
    .o_underflow     (o_underflow),
    .o_overflow      (o_overflow)
);
